### sv/bcomp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcomp_pkg
// Shared types and constants for the barometric compensation pipeline.
// ----------------------------------------------------------------------------
package bcomp_pkg;

    // Pipeline depth before and after the divider.
    localparam int PRE_STAGES  = 11;
    localparam int POST_STAGES = 6;

    // One quotient bit is resolved per divider stage.
    localparam int DIV_STAGES = 64;
    localparam int DEN_W      = 31;

    // Register indexes (byte address is 8 times the index).
    localparam logic [2:0] REG_TEMP_CAL    = 3'd0;
    localparam logic [2:0] REG_PRESS_FIRST = 3'd1;
    localparam logic [2:0] REG_PRESS_SECND = 3'd2;
    localparam logic [2:0] REG_PRESS_NINTH = 3'd3;
    localparam logic [2:0] REG_OFFSET      = 3'd4;

    // Accepted pressure window in Q24.8 pascals.
    localparam logic signed [33:0] VALID_LOW_Q8  = 34'sd7680000;
    localparam logic signed [33:0] VALID_HIGH_Q8 = 34'sd51200000;

    // Sideband that travels with an item through the divider.
    typedef struct packed {
        logic        neg;
        logic        zero;
        logic [31:0] temp;
    } bcomp_side_t;

endpackage

### sv/bcomp_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcomp_div
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module bcomp_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          vld_in,
    input  bcomp_pkg::bcomp_side_t        side_in,
    input  logic [63:0]                   num_in,
    input  logic [bcomp_pkg::DEN_W-1:0]   den_in,
    output logic                          vld_out,
    output bcomp_pkg::bcomp_side_t        side_out,
    output logic [63:0]                   quot_out
);
    import bcomp_pkg::*;

    logic [DIV_STAGES-1:0] vld_reg;
    bcomp_side_t           side_reg [DIV_STAGES];
    logic [DEN_W-1:0]      rem_reg  [DIV_STAGES];
    logic [DEN_W-1:0]      rem_next [DIV_STAGES];
    logic [DEN_W-1:0]      den_reg  [DIV_STAGES];
    logic [63:0]           dq_reg   [DIV_STAGES];
    logic [63:0]           dq_next  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic [DEN_W-1:0] r_in;
        logic [DEN_W-1:0] d_in;
        logic [63:0]      q_in;
        logic [DEN_W:0]   shifted;
        logic [DEN_W+1:0] diff;

        if (k == 0)
        begin : g_first
            assign r_in = '0;
            assign d_in = den_in;
            assign q_in = num_in;
        end
        else
        begin : g_next
            assign r_in = rem_reg[k-1];
            assign d_in = den_reg[k-1];
            assign q_in = dq_reg[k-1];
        end

        // Shift in the next dividend bit and try the subtraction.
        assign shifted     = {r_in, q_in[63]};
        assign diff        = {1'b0, shifted} - {2'b0, d_in};
        assign rem_next[k] = diff[DEN_W+1] ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
        assign dq_next[k]  = {q_in[62:0], ~diff[DEN_W+1]};

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= rem_next[k];
                dq_reg[k]   <= dq_next[k];
                den_reg[k]  <= d_in;
                side_reg[k] <= (k == 0) ? side_in : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], vld_in};
        end
    end

    assign vld_out  = vld_reg[DIV_STAGES-1];
    assign side_out = side_reg[DIV_STAGES-1];
    assign quot_out = dq_reg[DIV_STAGES-1];

endmodule

### sv/baro_sensor_compensation_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_sensor_compensation_core
// Integer temperature and 64-bit pressure compensation of a raw sample pair,
// with a pressure offset, saturation and a range flag.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake             Content
//  in        sink       in_valid / in_stall   raw_pressure, raw_temperature
//  out       source     out_valid / out_stall temperature_centi, pressure_fixed,
//                                             pressure_valid
//  config    APB slave  psel/penable/pready   five calibration and offset registers
//
// The block takes one item per clock while in_stall is low, and the edge
// that accepts an item loads the first of 82 register stages:
// eleven stages of temperature and product arithmetic, a 64-stage divider that
// resolves one quotient bit per stage, six stages of post-division products,
// and the output register. Reset clears all valid bits and the configuration.
// A stalled output parks one result in a skid register; in_stall is raised
// only while that skid register is full, and the whole pipeline then holds.
// ----------------------------------------------------------------------------
module baro_sensor_compensation_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [19:0]        raw_pressure,
    input  logic [19:0]        raw_temperature,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] temperature_centi,
    output logic [31:0]        pressure_fixed,
    output logic               pressure_valid,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [5:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);
    import bcomp_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers. Write them only while the block is idle;
    // the block does not enforce this. The stages that use them read them directly.
    // ------------------------------------------------------------------
    logic [47:0]        temp_cal_reg;
    logic [63:0]        press_first_reg;
    logic [63:0]        press_second_reg;
    logic signed [15:0] p9_reg;
    logic signed [22:0] offset_reg;
    logic               cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_reg     <= '0;
            press_first_reg  <= '0;
            press_second_reg <= '0;
            p9_reg           <= '0;
            offset_reg       <= '0;
        end
        else if (cfg_wr)
        begin
            case (paddr[5:3])
                REG_TEMP_CAL:    temp_cal_reg     <= pwdata[47:0];
                REG_PRESS_FIRST: press_first_reg  <= pwdata;
                REG_PRESS_SECND: press_second_reg <= pwdata;
                REG_PRESS_NINTH: p9_reg           <= pwdata[15:0];
                REG_OFFSET:      offset_reg       <= pwdata[22:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[5:3])
            REG_TEMP_CAL:    prdata = {16'b0, temp_cal_reg};
            REG_PRESS_FIRST: prdata = press_first_reg;
            REG_PRESS_SECND: prdata = press_second_reg;
            REG_PRESS_NINTH: prdata = {48'b0, p9_reg};
            REG_OFFSET:      prdata = {41'b0, offset_reg};
            default:         prdata = '0;
        endcase
    end

    // Calibration coefficients as slices of the registers.
    logic [15:0]        t1;
    logic signed [15:0] t2, t3;
    logic [15:0]        p1;
    logic signed [15:0] p2, p3, p4, p5, p6, p7, p8;

    assign t1 = temp_cal_reg[15:0];
    assign t2 = temp_cal_reg[31:16];
    assign t3 = temp_cal_reg[47:32];
    assign p1 = press_first_reg[15:0];
    assign p2 = press_first_reg[31:16];
    assign p3 = press_first_reg[47:32];
    assign p4 = press_first_reg[63:48];
    assign p5 = press_second_reg[15:0];
    assign p6 = press_second_reg[31:16];
    assign p7 = press_second_reg[47:32];
    assign p8 = press_second_reg[63:48];

    // ------------------------------------------------------------------
    // Flow control. The pipeline advances as a whole unless the skid
    // register holds a result.
    // ------------------------------------------------------------------
    logic adv;
    logic skid_vld_reg;
    logic out_vld_reg;

    assign adv      = !skid_vld_reg;
    assign in_stall = skid_vld_reg;

    logic [PRE_STAGES-1:0]  pre_vld_reg;
    logic [POST_STAGES-1:0] post_vld_reg;
    logic                   div_vld;

    // ------------------------------------------------------------------
    // Stage 1: temperature differences and their first products.
    // ------------------------------------------------------------------
    logic signed [17:0] s1_a;
    logic signed [33:0] s1_at;
    logic signed [16:0] s1_b;
    logic signed [33:0] s1_bb;
    logic signed [31:0] s1_v1t_reg;
    logic signed [19:0] s1_bbs_reg;
    logic [19:0]        s1_adc_reg;

    assign s1_a  = $signed({1'b0, raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign s1_at = s1_a * t2;
    assign s1_b  = $signed({1'b0, raw_temperature[19:4]}) - $signed({1'b0, t1});
    assign s1_bb = s1_b * s1_b;

    // Stage 2: second temperature term and the fine temperature.
    logic signed [35:0] s2_m;
    logic signed [31:0] s2_v2t;
    logic signed [31:0] s2_fine_reg;
    logic [19:0]        s2_adc_reg;

    assign s2_m   = s1_bbs_reg * t3;
    assign s2_v2t = $signed(s2_m[31:0]) >>> 14;

    // Stage 3: centidegrees and the pressure offset variable x.
    logic [31:0]        s3_t5;
    logic signed [32:0] s3_x;
    logic signed [32:0] s3_x_reg;
    logic [31:0]        s3_temp_reg;
    logic [19:0]        s3_adc_reg;

    assign s3_t5 = s2_fine_reg + {s2_fine_reg[29:0], 2'b0} + 32'd128;
    assign s3_x  = $signed({s2_fine_reg[31], s2_fine_reg}) - 33'sd128000;

    // Stage 4: x squared and the linear products.
    logic signed [65:0] s4_xx;
    logic signed [48:0] s4_xp5, s4_xp2;
    logic [63:0]        s4_xx_reg;
    logic signed [48:0] s4_xp5_reg, s4_xp2_reg;
    logic [31:0]        s4_temp_reg;
    logic [19:0]        s4_adc_reg;

    assign s4_xx  = s3_x_reg * s3_x_reg;
    assign s4_xp5 = s3_x_reg * p5;
    assign s4_xp2 = s3_x_reg * p2;

    // Stage 5: x squared times p6 and p3, split in 32-bit halves.
    logic signed [48:0] s5_m6l, s5_m3l;
    logic signed [47:0] s5_m6h, s5_m3h;
    logic signed [48:0] s5_m6l_reg, s5_m3l_reg;
    logic [31:0]        s5_m6h_reg, s5_m3h_reg;
    logic signed [48:0] s5_xp5_reg, s5_xp2_reg;
    logic [31:0]        s5_temp_reg;
    logic [19:0]        s5_adc_reg;

    assign s5_m6l = $signed({1'b0, s4_xx_reg[31:0]}) * p6;
    assign s5_m6h = $signed(s4_xx_reg[63:32]) * p6;
    assign s5_m3l = $signed({1'b0, s4_xx_reg[31:0]}) * p3;
    assign s5_m3h = $signed(s4_xx_reg[63:32]) * p3;

    // Stage 6: join the halves.
    logic [63:0]        s6_m6_reg, s6_m3_reg;
    logic signed [48:0] s6_xp5_reg, s6_xp2_reg;
    logic [31:0]        s6_temp_reg;
    logic [19:0]        s6_adc_reg;

    // Stage 7: the two intermediate pressure variables.
    logic [63:0] s7_v2, s7_v1a;
    logic [63:0] s7_v2_reg, s7_v1a_reg;
    logic [31:0] s7_temp_reg;
    logic [19:0] s7_adc_reg;

    assign s7_v2  = s6_m6_reg
                  + ({{15{s6_xp5_reg[48]}}, s6_xp5_reg} << 17)
                  + {{13{p4[15]}}, p4, 35'b0};
    assign s7_v1a = {{8{s6_m3_reg[63]}}, s6_m3_reg[63:8]}
                  + ({{15{s6_xp2_reg[48]}}, s6_xp2_reg} << 12)
                  + (64'd1 << 47);

    // Stage 8: divisor product halves and the numerator difference.
    logic [47:0] s8_dl, s8_dh;
    logic [20:0] s8_pp;
    logic [47:0] s8_dl_reg;
    logic [31:0] s8_dh_reg;
    logic [63:0] s8_nsub_reg;
    logic [31:0] s8_temp_reg;

    assign s8_dl = s7_v1a_reg[31:0] * p1;
    assign s8_dh = s7_v1a_reg[63:32] * p1;
    assign s8_pp = 21'd1048576 - {1'b0, s7_adc_reg};

    // Stage 9: divisor and the numerator times 3125 in halves.
    logic [63:0]        s9_prod;
    logic [43:0]        s9_nl, s9_nh;
    logic signed [30:0] s9_den_reg;
    logic [43:0]        s9_nl_reg;
    logic [31:0]        s9_nh_reg;
    logic [31:0]        s9_temp_reg;

    assign s9_prod = {16'b0, s8_dl_reg} + {s8_dh_reg, 32'b0};
    assign s9_nl   = s8_nsub_reg[31:0] * 12'd3125;
    assign s9_nh   = s8_nsub_reg[63:32] * 12'd3125;

    // Stage 10: full numerator.
    logic [63:0]        s10_num_reg;
    logic signed [30:0] s10_den_reg;
    logic [31:0]        s10_temp_reg;

    // Stage 11: magnitudes and the quotient sign.
    logic [31:0]       s11_dmag;
    logic [63:0]       s11_nmag_reg;
    logic [DEN_W-1:0]  s11_dmag_reg;
    bcomp_side_t       s11_side_reg;

    assign s11_dmag = s10_den_reg[30] ? (32'd0 - {s10_den_reg[30], s10_den_reg})
                                      : {1'b0, s10_den_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_v1t_reg   <= $signed(s1_at[31:0]) >>> 11;
            s1_bbs_reg   <= s1_bb[31:12];
            s1_adc_reg   <= raw_pressure;

            s2_fine_reg  <= s1_v1t_reg + s2_v2t;
            s2_adc_reg   <= s1_adc_reg;

            s3_temp_reg  <= $signed(s3_t5) >>> 8;
            s3_x_reg     <= s3_x;
            s3_adc_reg   <= s2_adc_reg;

            s4_xx_reg    <= s4_xx[63:0];
            s4_xp5_reg   <= s4_xp5;
            s4_xp2_reg   <= s4_xp2;
            s4_temp_reg  <= s3_temp_reg;
            s4_adc_reg   <= s3_adc_reg;

            s5_m6l_reg   <= s5_m6l;
            s5_m6h_reg   <= s5_m6h[31:0];
            s5_m3l_reg   <= s5_m3l;
            s5_m3h_reg   <= s5_m3h[31:0];
            s5_xp5_reg   <= s4_xp5_reg;
            s5_xp2_reg   <= s4_xp2_reg;
            s5_temp_reg  <= s4_temp_reg;
            s5_adc_reg   <= s4_adc_reg;

            s6_m6_reg    <= {{15{s5_m6l_reg[48]}}, s5_m6l_reg} + {s5_m6h_reg, 32'b0};
            s6_m3_reg    <= {{15{s5_m3l_reg[48]}}, s5_m3l_reg} + {s5_m3h_reg, 32'b0};
            s6_xp5_reg   <= s5_xp5_reg;
            s6_xp2_reg   <= s5_xp2_reg;
            s6_temp_reg  <= s5_temp_reg;
            s6_adc_reg   <= s5_adc_reg;

            s7_v2_reg    <= s7_v2;
            s7_v1a_reg   <= s7_v1a;
            s7_temp_reg  <= s6_temp_reg;
            s7_adc_reg   <= s6_adc_reg;

            s8_dl_reg    <= s8_dl;
            s8_dh_reg    <= s8_dh[31:0];
            s8_nsub_reg  <= ({43'b0, s8_pp} << 31) - s7_v2_reg;
            s8_temp_reg  <= s7_temp_reg;

            s9_den_reg   <= s9_prod[63:33];
            s9_nl_reg    <= s9_nl;
            s9_nh_reg    <= s9_nh[31:0];
            s9_temp_reg  <= s8_temp_reg;

            s10_num_reg  <= {20'b0, s9_nl_reg} + {s9_nh_reg, 32'b0};
            s10_den_reg  <= s9_den_reg;
            s10_temp_reg <= s9_temp_reg;

            s11_nmag_reg      <= s10_num_reg[63] ? (64'd0 - s10_num_reg) : s10_num_reg;
            s11_dmag_reg      <= s11_dmag[DEN_W-1:0];
            s11_side_reg.neg  <= s10_num_reg[63] ^ s10_den_reg[30];
            s11_side_reg.zero <= (s10_den_reg == '0);
            s11_side_reg.temp <= s10_temp_reg;
        end
    end

    // ------------------------------------------------------------------
    // Divider: truncating quotient of the magnitudes.
    // ------------------------------------------------------------------
    bcomp_side_t div_side;
    logic [63:0] div_quot;

    bcomp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .vld_in   (pre_vld_reg[PRE_STAGES-1]),
        .side_in  (s11_side_reg),
        .num_in   (s11_nmag_reg),
        .den_in   (s11_dmag_reg),
        .vld_out  (div_vld),
        .side_out (div_side),
        .quot_out (div_quot)
    );

    // Post A: signed quotient.
    logic [63:0] pa_p_reg;
    logic        pa_zero_reg;
    logic [31:0] pa_temp_reg;

    // Post B: square of p >>> 13 in halves, and p times p8 in halves.
    logic [50:0]        pb_q13;
    logic [63:0]        pb_lsq;
    logic signed [52:0] pb_cross;
    logic signed [48:0] pb_p8l;
    logic signed [47:0] pb_p8h;
    logic [63:0]        pb_lsq_reg;
    logic [30:0]        pb_cross_reg;
    logic signed [48:0] pb_p8l_reg;
    logic [31:0]        pb_p8h_reg;
    logic [63:0]        pb_p_reg;
    logic               pb_zero_reg;
    logic [31:0]        pb_temp_reg;

    assign pb_q13   = pa_p_reg[63:13];
    assign pb_lsq   = pb_q13[31:0] * pb_q13[31:0];
    assign pb_cross = $signed({1'b0, pb_q13[31:0]}) * $signed(pb_q13[50:32]);
    assign pb_p8l   = $signed({1'b0, pa_p_reg[31:0]}) * p8;
    assign pb_p8h   = $signed(pa_p_reg[63:32]) * p8;

    // Post C: full square and the p8 term.
    logic [63:0] pc_p8p;
    logic [63:0] pc_sq_reg;
    logic [63:0] pc_v2_reg;
    logic [63:0] pc_p_reg;
    logic        pc_zero_reg;
    logic [31:0] pc_temp_reg;

    assign pc_p8p = {{15{pb_p8l_reg[48]}}, pb_p8l_reg} + {pb_p8h_reg, 32'b0};

    // Post D: square times p9 in halves.
    logic signed [48:0] pd_sl;
    logic signed [47:0] pd_sh;
    logic signed [48:0] pd_sl_reg;
    logic [31:0]        pd_sh_reg;
    logic [63:0]        pd_v2_reg;
    logic [63:0]        pd_p_reg;
    logic               pd_zero_reg;
    logic [31:0]        pd_temp_reg;

    assign pd_sl = $signed({1'b0, pc_sq_reg[31:0]}) * p9_reg;
    assign pd_sh = $signed(pc_sq_reg[63:32]) * p9_reg;

    // Post E: the p9 term.
    logic [63:0] pe_s;
    logic [63:0] pe_v1_reg;
    logic [63:0] pe_v2_reg;
    logic [63:0] pe_p_reg;
    logic        pe_zero_reg;
    logic [31:0] pe_temp_reg;

    assign pe_s = {{15{pd_sl_reg[48]}}, pd_sl_reg} + {pd_sh_reg, 32'b0};

    // Post F: final sum. Only its low 32 bits after the shift are kept,
    // so a 40-bit add is enough.
    logic [39:0] pf_s40;
    logic [31:0] pf_comp;
    logic [31:0] pf_comp_reg;
    logic [31:0] pf_temp_reg;

    assign pf_s40  = pe_p_reg[39:0] + pe_v1_reg[39:0] + pe_v2_reg[39:0];
    assign pf_comp = pe_zero_reg ? 32'd0 : (pf_s40[39:8] + {{12{p7[15]}}, p7, 4'b0});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_p_reg     <= div_side.neg ? (64'd0 - div_quot) : div_quot;
            pa_zero_reg  <= div_side.zero;
            pa_temp_reg  <= div_side.temp;

            pb_lsq_reg   <= pb_lsq;
            pb_cross_reg <= pb_cross[30:0];
            pb_p8l_reg   <= pb_p8l;
            pb_p8h_reg   <= pb_p8h[31:0];
            pb_p_reg     <= pa_p_reg;
            pb_zero_reg  <= pa_zero_reg;
            pb_temp_reg  <= pa_temp_reg;

            pc_sq_reg    <= pb_lsq_reg + {pb_cross_reg, 33'b0};
            pc_v2_reg    <= {{19{pc_p8p[63]}}, pc_p8p[63:19]};
            pc_p_reg     <= pb_p_reg;
            pc_zero_reg  <= pb_zero_reg;
            pc_temp_reg  <= pb_temp_reg;

            pd_sl_reg    <= pd_sl;
            pd_sh_reg    <= pd_sh[31:0];
            pd_v2_reg    <= pc_v2_reg;
            pd_p_reg     <= pc_p_reg;
            pd_zero_reg  <= pc_zero_reg;
            pd_temp_reg  <= pc_temp_reg;

            pe_v1_reg    <= {{25{pe_s[63]}}, pe_s[63:25]};
            pe_v2_reg    <= pd_v2_reg;
            pe_p_reg     <= pd_p_reg;
            pe_zero_reg  <= pd_zero_reg;
            pe_temp_reg  <= pd_temp_reg;

            pf_comp_reg  <= pf_comp;
            pf_temp_reg  <= pe_temp_reg;
        end
    end

    // ------------------------------------------------------------------
    // Offset, saturation and range flag on the exact sum.
    // ------------------------------------------------------------------
    logic signed [33:0] fin_sum;
    logic [31:0]        fin_sat;
    logic               fin_pv;
    logic               fin_vld;

    assign fin_sum = $signed({2'b0, pf_comp_reg}) + $signed({{11{offset_reg[22]}}, offset_reg});
    assign fin_sat = fin_sum[33] ? 32'd0 : (fin_sum[32] ? 32'hFFFF_FFFF : fin_sum[31:0]);
    assign fin_pv  = (fin_sum >= VALID_LOW_Q8) && (fin_sum <= VALID_HIGH_Q8);
    assign fin_vld = post_vld_reg[POST_STAGES-1];

    // ------------------------------------------------------------------
    // Valid bits, output register and skid register.
    // ------------------------------------------------------------------
    logic               to_out;
    logic               to_skid;
    logic               skid_to_out;
    logic signed [31:0] out_temp_reg, skid_temp_reg;
    logic [31:0]        out_press_reg, skid_press_reg;
    logic               out_pv_reg, skid_pv_reg;

    assign to_out      = adv && fin_vld && (!out_vld_reg || !out_stall);
    assign to_skid     = adv && fin_vld && out_vld_reg && out_stall;
    assign skid_to_out = skid_vld_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_vld_reg  <= '0;
            post_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                pre_vld_reg  <= {pre_vld_reg[PRE_STAGES-2:0], in_valid};
                post_vld_reg <= {post_vld_reg[POST_STAGES-2:0], div_vld};
            end
            if (to_out || skid_to_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end
            if (to_skid)
            begin
                skid_vld_reg <= 1'b1;
            end
            else if (skid_to_out)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (to_out)
        begin
            out_temp_reg  <= pf_temp_reg;
            out_press_reg <= fin_sat;
            out_pv_reg    <= fin_pv;
        end
        else if (skid_to_out)
        begin
            out_temp_reg  <= skid_temp_reg;
            out_press_reg <= skid_press_reg;
            out_pv_reg    <= skid_pv_reg;
        end
        if (to_skid)
        begin
            skid_temp_reg  <= pf_temp_reg;
            skid_press_reg <= fin_sat;
            skid_pv_reg    <= fin_pv;
        end
    end

    assign out_valid         = out_vld_reg;
    assign temperature_centi = out_temp_reg;
    assign pressure_fixed    = out_press_reg;
    assign pressure_valid    = out_pv_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The skid register only fills behind a held output.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid register full while output register is empty");

    // The skid register fills only when the output was stalled.
    a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_vld_reg) |-> $past(out_vld_reg && out_stall))
        else $error("skid register filled without an output stall");

    // A result flagged in range lies inside the valid pressure window.
    a_range_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pressure_valid) |->
            (pressure_fixed >= 32'd7680000 && pressure_fixed <= 32'd51200000))
        else $error("range flag set on out-of-range pressure");

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for baro_sensor_compensation_core. A directed table of
// sample pairs runs first, under fixed calibration sets (reset values, a
// typical calibration, offset extremes, all-ones words and a zero divisor).
// Random phases with realistic and fully random calibrations follow. Every
// accepted item with no typed expectation goes through a local compensation
// predictor; results are compared in order, field by field, as delivered.
// ----------------------------------------------------------------------------
module tb_top;
    import bcomp_pkg::*;

    // A compensated result as the block reports it.
    typedef struct {
        logic signed [31:0] centi;
        logic [31:0]        fixed_q8;
        logic               in_range;
    } comp_result_t;

    // One item waiting to be offered, with an optional typed expectation.
    typedef struct {
        logic [19:0]  raw_p;
        logic [19:0]  raw_t;
        bit           known;
        comp_result_t want;
    } sample_t;

    // One complete set of calibration and offset register values.
    typedef struct {
        logic [47:0] temp_words;
        logic [63:0] press_first;
        logic [63:0] press_second;
        logic [15:0] press_ninth;
        logic [22:0] offset_q8;
    } cal_set_t;

    typedef struct {
        int           set_id;
        logic [19:0]  raw_p;
        logic [19:0]  raw_t;
        bit           known;
        comp_result_t want;
    } row_t;

    localparam int LATENCY_WAIT = 120;
    localparam int LONG_HOLD    = 300;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [19:0]        raw_pressure;
    logic [19:0]        raw_temperature;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_fixed;
    logic               pressure_valid;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [5:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;

    baro_sensor_compensation_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .raw_pressure     (raw_pressure),
        .raw_temperature  (raw_temperature),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .temperature_centi(temperature_centi),
        .pressure_fixed   (pressure_fixed),
        .pressure_valid   (pressure_valid),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // The bench's own copy of the register file, used by the predictor.
    cal_set_t     cal_now;
    sample_t      pending_samples[$];
    comp_result_t expected_results[$];
    sample_t      offered;
    int           error_count;
    bit           quiet_tail;      // no idling on either side in the last phase
    bit           long_hold_req;   // receiver holds out_stall high until hold_count reaches LONG_HOLD
    int           send_gap;
    int           recv_gap;
    int           hold_count;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Generous limit: every item with the longest gap and stall, many times over.
    initial
    begin
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch on %s: got %0h, expected %0h", what, got, want);
        error_count++;
    endtask

    function automatic logic signed [63:0] slice_s16(input logic [63:0] w, input int k);
        logic signed [15:0] s;
        s = w[16*k +: 16];
        return 64'(s);
    endfunction

    // Integer temperature compensation in 32 bits and pressure compensation in
    // 64 bits, both wrapping, with arithmetic right shifts throughout.
    function automatic comp_result_t compensate(input logic [19:0] adc_p,
                                                input logic [19:0] adc_t,
                                                input cal_set_t c);
        logic signed [31:0] t1, t2, t3, a, b, v1t, v2t, bb, fine;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] x, v1, v2, p, num, q13, xx;
        logic signed [34:0] sum;
        logic [31:0]        comp;
        comp_result_t       r;
        t1 = {16'd0, c.temp_words[15:0]};
        t2 = 32'(slice_s16({16'd0, c.temp_words}, 1));
        t3 = 32'(slice_s16({16'd0, c.temp_words}, 2));
        p1 = {48'd0, c.press_first[15:0]};
        p2 = slice_s16(c.press_first, 1);
        p3 = slice_s16(c.press_first, 2);
        p4 = slice_s16(c.press_first, 3);
        p5 = slice_s16(c.press_second, 0);
        p6 = slice_s16(c.press_second, 1);
        p7 = slice_s16(c.press_second, 2);
        p8 = slice_s16(c.press_second, 3);
        p9 = slice_s16({48'd0, c.press_ninth}, 0);

        a    = {15'd0, adc_t[19:3]} - (t1 <<< 1);
        v1t  = a * t2;
        v1t  = v1t >>> 11;
        b    = {16'd0, adc_t[19:4]} - t1;
        bb   = b * b;
        bb   = bb >>> 12;
        v2t  = bb * t3;
        v2t  = v2t >>> 14;
        fine = v1t + v2t;
        r.centi = (fine * 32'sd5 + 32'sd128) >>> 8;

        x  = 64'(fine) - 64'sd128000;
        xx = x * x;
        v2 = xx * p6;
        v2 = v2 + ((x * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = xx * p3;
        v1 = (v1 >>> 8) + ((x * p2) <<< 12);
        v1 = ((64'sd1 <<< 47) + v1) * p1;
        v1 = v1 >>> 33;
        if (v1 == 64'sd0)
        begin
            comp = 32'd0;
        end
        else
        begin
            p   = 64'sd1048576 - {44'd0, adc_p};
            num = ((p <<< 31) - v2) * 64'sd3125;
            // The one overflowing quotient wraps to the most negative value.
            if (num == {1'b1, 63'd0} && v1 == -64'sd1)
                p = num;
            else
                p = num / v1;
            q13  = p >>> 13;
            v1   = p9 * q13 * q13;
            v1   = v1 >>> 25;
            v2   = p8 * p;
            v2   = v2 >>> 19;
            p    = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            comp = p[31:0];
        end

        // The offset sum is exact; saturation and the range flag both use it.
        sum = $signed({3'd0, comp}) + 35'($signed(c.offset_q8));
        if (sum < 0)
            r.fixed_q8 = 32'd0;
        else if (sum > 35'sh0_FFFF_FFFF)
            r.fixed_q8 = 32'hFFFF_FFFF;
        else
            r.fixed_q8 = sum[31:0];
        r.in_range = (sum >= 35'(VALID_LOW_Q8)) && (sum <= 35'(VALID_HIGH_Q8));
        return r;
    endfunction

    // Sender: offers queued items with random idle bursts; valid is held
    // and the payload frozen until the block accepts the item.
    always @(posedge clk)
    begin
        logic next_valid;
        if (rst_n)
        begin
            next_valid = in_valid;
            if (in_valid && !in_stall)
            begin
                expected_results.push_back(offered.known ? offered.want
                    : compensate(offered.raw_p, offered.raw_t, cal_now));
                next_valid = 1'b0;
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (pending_samples.size() > 0)
                begin
                    offered = pending_samples.pop_front();
                    raw_pressure    <= offered.raw_p;
                    raw_temperature <= offered.raw_t;
                    next_valid = 1'b1;
                    if (!quiet_tail && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 10);
                end
            end
            in_valid <= next_valid;
        end
    end

    // Receiver: checks each delivered result against the oldest expectation
    // and stalls in random bursts, or once for a long stretch on request.
    always @(posedge clk)
    begin
        comp_result_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result", 64'(pressure_fixed), 64'd0);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (temperature_centi !== want.centi)
                        report_mismatch("temperature_centi", 64'(temperature_centi),
                                        64'(want.centi));
                    if (pressure_fixed !== want.fixed_q8)
                        report_mismatch("pressure_fixed", 64'(pressure_fixed),
                                        64'(want.fixed_q8));
                    if (pressure_valid !== want.in_range)
                        report_mismatch("pressure_valid", 64'(pressure_valid),
                                        64'(want.in_range));
                end
            end
            if (long_hold_req)
            begin
                out_stall <= 1'b1;
                hold_count++;
                if (hold_count >= LONG_HOLD)
                    long_hold_req = 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (!quiet_tail && $urandom_range(0, 7) == 0)
                    recv_gap = $urandom_range(1, 10);
            end
        end
    end

    // APB write: a setup phase, then an access phase; pready is always high.
    task automatic apb_write(input logic [2:0] idx, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_calibration(input cal_set_t c);
        apb_write(REG_TEMP_CAL, {16'd0, c.temp_words});
        apb_write(REG_PRESS_FIRST, c.press_first);
        apb_write(REG_PRESS_SECND, c.press_second);
        apb_write(REG_PRESS_NINTH, {48'd0, c.press_ninth});
        apb_write(REG_OFFSET, {41'd0, c.offset_q8});
        cal_now = c;
    endtask

    // Wait until every item has gone in and every result has come out, then
    // give the pipeline its full depth to drain before touching registers.
    task automatic wait_drained();
        while (pending_samples.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    function automatic logic [15:0] jitter16(input int base, input int span);
        return 16'(base + $urandom_range(0, 2 * span) - span);
    endfunction

    // Realistic calibrations keep the pressure path well conditioned; the
    // others throw fully random words.
    function automatic cal_set_t random_calibration(input int mode);
        cal_set_t c;
        if (mode == 0)
        begin
            c.temp_words   = {jitter16(-1000, 200), jitter16(26435, 500),
                              jitter16(27504, 800)};
            c.press_first  = {jitter16(2855, 300), jitter16(3024, 300),
                              jitter16(-10685, 500), jitter16(36477, 1500)};
            c.press_second = {jitter16(-14600, 600), jitter16(15500, 600),
                              jitter16(-7, 5), jitter16(140, 40)};
            c.press_ninth  = jitter16(6000, 500);
        end
        else
        begin
            c.temp_words   = 48'({$urandom, $urandom});
            c.press_first  = {$urandom, $urandom};
            c.press_second = {$urandom, $urandom};
            c.press_ninth  = 16'($urandom);
        end
        case ($urandom_range(0, 5))
            0:       c.offset_q8 = 23'd2560000;
            1:       c.offset_q8 = 23'(-2560000);
            2:       c.offset_q8 = 23'd0;
            default: c.offset_q8 = 23'($signed($urandom_range(0, 5120000)) - 2560000);
        endcase
        return c;
    endfunction

    function automatic sample_t random_sample(input bit realistic);
        sample_t s;
        s.known = 1'b0;
        s.want  = '{default: '0};
        if (realistic)
        begin
            s.raw_p = 20'($urandom_range(250000, 600000));
            s.raw_t = 20'($urandom_range(400000, 640000));
        end
        else
        begin
            s.raw_p = 20'($urandom);
            s.raw_t = 20'($urandom);
        end
        return s;
    endfunction

    localparam cal_set_t TYPICAL = '{48'hFC18_6743_6B70, 64'h0B27_0BD0_D643_8E7D,
                                     64'hC6F8_3C8C_FFF9_008C, 16'h1770, 23'd0};

    cal_set_t cal_sets [7];
    row_t     directed_rows [20];

    initial
    begin
        sample_t s;
        int      cur_set;
        int      n_items;
        bit      realistic;

        cal_sets[0] = '{default: '0};
        cal_sets[1] = TYPICAL;
        cal_sets[2] = TYPICAL;
        cal_sets[2].offset_q8 = 23'd2560000;
        cal_sets[3] = TYPICAL;
        cal_sets[3].offset_q8 = 23'(-2560000);
        cal_sets[4] = '{48'hFFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                        64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 23'h3F_FFFF};
        cal_sets[5] = '{default: '0};
        cal_sets[5].offset_q8 = 23'd2560000;
        cal_sets[6] = '{default: '0};
        cal_sets[6].offset_q8 = 23'(-2560000);

        // Set 0 is the state after reset: every coefficient is zero, so the
        // divisor is zero and all outputs are zero. Sets 5 and 6 keep the
        // zero divisor but add the largest offsets, which shows up unchanged
        // or is clamped at zero.
        directed_rows = '{
            '{0, 20'd0,       20'd0,       1, '{32'sd0, 32'd0, 1'b0}},
            '{0, 20'hFFFFF,   20'hFFFFF,   1, '{32'sd0, 32'd0, 1'b0}},
            '{0, 20'd0,       20'hFFFFF,   1, '{32'sd0, 32'd0, 1'b0}},
            '{0, 20'hFFFFF,   20'd0,       1, '{32'sd0, 32'd0, 1'b0}},
            '{1, 20'd415148,  20'd519888,  0, '{default: '0}},
            '{1, 20'd0,       20'd519888,  0, '{default: '0}},
            '{1, 20'hFFFFF,   20'd519888,  0, '{default: '0}},
            '{1, 20'd415148,  20'd0,       0, '{default: '0}},
            '{1, 20'd415148,  20'hFFFFF,   0, '{default: '0}},
            '{1, 20'hAAAAA,   20'h55555,   0, '{default: '0}},
            '{2, 20'd415148,  20'd519888,  0, '{default: '0}},
            '{2, 20'd0,       20'd0,       0, '{default: '0}},
            '{3, 20'd415148,  20'd519888,  0, '{default: '0}},
            '{3, 20'hFFFFF,   20'hFFFFF,   0, '{default: '0}},
            '{4, 20'd0,       20'd0,       0, '{default: '0}},
            '{4, 20'hFFFFF,   20'hFFFFF,   0, '{default: '0}},
            '{4, 20'h55555,   20'hAAAAA,   0, '{default: '0}},
            '{5, 20'd415148,  20'd519888,  1, '{32'sd0, 32'd2560000, 1'b0}},
            '{5, 20'hFFFFF,   20'hFFFFF,   1, '{32'sd0, 32'd2560000, 1'b0}},
            '{6, 20'd415148,  20'd519888,  1, '{32'sd0, 32'd0, 1'b0}}
        };

        error_count     = 0;
        quiet_tail      = 1'b0;
        long_hold_req   = 1'b0;
        send_gap        = 0;
        recv_gap        = 0;
        hold_count      = 0;
        cal_now         = cal_sets[0];
        in_valid        = 1'b0;
        raw_pressure    = '0;
        raw_temperature = '0;
        out_stall       = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        rst_n           = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; the register set changes only between drained phases.
        cur_set = 0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].set_id != cur_set)
            begin
                wait_drained();
                cur_set = directed_rows[i].set_id;
                load_calibration(cal_sets[cur_set]);
            end
            s.raw_p = directed_rows[i].raw_p;
            s.raw_t = directed_rows[i].raw_t;
            s.known = directed_rows[i].known;
            s.want  = directed_rows[i].want;
            pending_samples.push_back(s);
        end

        // Random phases. Most use a realistic calibration and sample pairs
        // near room conditions so the pressure reaches the valid window.
        for (int phase = 0; phase < 12; phase++)
        begin
            wait_drained();
            load_calibration(random_calibration((phase % 4 == 3) ? 1 : 0));
            quiet_tail = (phase == 11);
            n_items = (phase == 4) ? 200 : 85;
            for (int k = 0; k < n_items; k++)
            begin
                realistic = ($urandom_range(0, 9) < 7);
                pending_samples.push_back(random_sample(realistic));
            end
            // Back the output up long enough for the pipeline to fill and
            // raise in_stall while the sender keeps offering.
            if (phase == 4)
                long_hold_req = 1'b1;
        end

        wait_drained();
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
